>>> rtl/spq_pkg.sv
// shared constants, codes and control structs for the sorted priority queue
// no dependencies; used by every module of the block
package spq_pkg;

  localparam int Depth   = 16;
  localparam int TagBits = 16;
  localparam int KeyW    = 32;
  localparam int TagW    = 16;
  localparam int OccW    = 5;
  localparam int CmdW    = 2;
  localparam int StW     = 2;
  localparam int CntW    = $clog2(Depth + 1);
  localparam int IdxW    = $clog2(Depth);

  localparam logic [CmdW-1:0] CmdEnq  = 2'd0;
  localparam logic [CmdW-1:0] CmdDeq  = 2'd1;
  localparam logic [CmdW-1:0] CmdPeek = 2'd2;
  localparam logic [CmdW-1:0] CmdDump = 2'd3;

  localparam logic [StW-1:0] StOk    = 2'd0;
  localparam logic [StW-1:0] StEmpty = 2'd1;
  localparam logic [StW-1:0] StFull  = 2'd2;

  typedef logic [2:0] op_t;
  localparam op_t OpNone      = 3'd0;
  localparam op_t OpEnq       = 3'd1;
  localparam op_t OpDeq       = 3'd2;
  localparam op_t OpPeek      = 3'd3;
  localparam op_t OpDumpFirst = 3'd4;
  localparam op_t OpDumpNext  = 3'd5;

  typedef struct packed {
    logic capture;
    op_t  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            empty;
    logic            single;
    logic            dump_last;
  } dp_stat_t;

endpackage

>>> rtl/spq_ctrl.sv
// controller state machine of the sorted priority queue
// depends on spq_pkg; drives the datapath through ctrl_cmd_t
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::dp_stat_t stat,
  output spq_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = spq_pkg::OpNone;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (stat.cmd)
          spq_pkg::CmdEnq:  cmd.op = spq_pkg::OpEnq;
          spq_pkg::CmdDeq:  cmd.op = spq_pkg::OpDeq;
          spq_pkg::CmdPeek: cmd.op = spq_pkg::OpPeek;
          spq_pkg::CmdDump: begin
            cmd.op = spq_pkg::OpDumpFirst;
            // more than one entry: keep walking the row
            if (!stat.empty && !stat.single) begin
              state_nxt = S_DUMP;
            end
          end
          default: cmd.op = spq_pkg::OpNone;
        endcase
      end
      S_DUMP: begin
        cmd.op = spq_pkg::OpDumpNext;
        if (stat.dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/spq_datapath.sv
// entry row with parallel compare-and-shift, dump pointer and result registers
// depends on spq_pkg; commanded by spq_ctrl
module spq_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spq_pkg::ctrl_cmd_t           cmd,
  output spq_pkg::dp_stat_t            stat,
  input  logic [spq_pkg::CmdW-1:0]     in_command,
  input  logic signed [spq_pkg::KeyW-1:0] in_key,
  input  logic [spq_pkg::TagW-1:0]     in_tag,
  output logic                         out_valid,
  output logic [spq_pkg::StW-1:0]      out_status,
  output logic signed [spq_pkg::KeyW-1:0] out_key,
  output logic [spq_pkg::TagW-1:0]     out_tag,
  output logic [spq_pkg::OccW-1:0]     out_occupancy,
  output logic                         out_last
);

  localparam int Depth = spq_pkg::Depth;
  localparam int CntW  = spq_pkg::CntW;
  localparam int IdxW  = spq_pkg::IdxW;

  logic signed [spq_pkg::KeyW-1:0]  key_r [Depth];
  logic signed [spq_pkg::KeyW-1:0]  key_nxt [Depth];
  logic [spq_pkg::TagBits-1:0]      tag_r [Depth];
  logic [spq_pkg::TagBits-1:0]      tag_nxt [Depth];
  logic [CntW-1:0]                  count_r, count_nxt;
  logic [IdxW-1:0]                  idx_r, idx_nxt;

  logic [spq_pkg::CmdW-1:0]         cmd_r;
  logic signed [spq_pkg::KeyW-1:0]  in_key_r;
  logic [spq_pkg::TagBits-1:0]      in_tag_r;

  logic                             valid_r, valid_nxt;
  logic [spq_pkg::StW-1:0]          st_r, st_nxt;
  logic signed [spq_pkg::KeyW-1:0]  okey_r, okey_nxt;
  logic [spq_pkg::TagW-1:0]         otag_r, otag_nxt;
  logic [spq_pkg::OccW-1:0]         occ_r, occ_nxt;
  logic                             last_r, last_nxt;

  logic [Depth-1:0]                 le;
  logic [Depth-1:0]                 ins;
  logic                             full;
  logic                             empty;

  assign full  = (count_r == CntW'(Depth));
  assign empty = (count_r == '0);

  assign stat.cmd       = cmd_r;
  assign stat.empty     = empty;
  assign stat.single    = (count_r == CntW'(1));
  assign stat.dump_last = (CntW'(idx_r) == count_r - CntW'(1));

  // le marks entries that stay ahead of the new item; ins marks its slot
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      le[i] = (CntW'(i) < count_r) && (key_r[i] <= in_key_r);
    end
    ins[0] = !le[0];
    for (int i = 1; i < Depth; i++) begin
      ins[i] = !le[i] && le[i-1];
    end
  end

  always_comb begin
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    valid_nxt = 1'b0;
    st_nxt    = st_r;
    okey_nxt  = okey_r;
    otag_nxt  = otag_r;
    last_nxt  = last_r;
    unique case (cmd.op)
      spq_pkg::OpEnq: begin
        valid_nxt = 1'b1;
        last_nxt  = 1'b1;
        if (full) begin
          st_nxt   = spq_pkg::StFull;
          okey_nxt = key_r[0];
          otag_nxt = spq_pkg::TagW'(tag_r[0]);
        end else begin
          st_nxt = spq_pkg::StOk;
          if (ins[0]) begin
            key_nxt[0] = in_key_r;
            tag_nxt[0] = in_tag_r;
          end
          for (int i = 1; i < Depth; i++) begin
            if (ins[i]) begin
              key_nxt[i] = in_key_r;
              tag_nxt[i] = in_tag_r;
            end else if (!le[i]) begin
              key_nxt[i] = key_r[i-1];
              tag_nxt[i] = tag_r[i-1];
            end
          end
          count_nxt = count_r + CntW'(1);
          okey_nxt  = ins[0] ? in_key_r : key_r[0];
          otag_nxt  = spq_pkg::TagW'(ins[0] ? in_tag_r : tag_r[0]);
        end
      end
      spq_pkg::OpDeq: begin
        valid_nxt = 1'b1;
        last_nxt  = 1'b1;
        if (empty) begin
          st_nxt   = spq_pkg::StEmpty;
          okey_nxt = '0;
          otag_nxt = '0;
        end else begin
          st_nxt = spq_pkg::StOk;
          for (int i = 0; i < Depth - 1; i++) begin
            key_nxt[i] = key_r[i+1];
            tag_nxt[i] = tag_r[i+1];
          end
          count_nxt = count_r - CntW'(1);
          if (count_r > CntW'(1)) begin
            okey_nxt = key_r[1];
            otag_nxt = spq_pkg::TagW'(tag_r[1]);
          end else begin
            okey_nxt = '0;
            otag_nxt = '0;
          end
        end
      end
      spq_pkg::OpPeek, spq_pkg::OpDumpFirst: begin
        valid_nxt = 1'b1;
        idx_nxt   = IdxW'(1);
        if (empty) begin
          st_nxt   = spq_pkg::StEmpty;
          okey_nxt = '0;
          otag_nxt = '0;
          last_nxt = 1'b1;
        end else begin
          st_nxt   = spq_pkg::StOk;
          okey_nxt = key_r[0];
          otag_nxt = spq_pkg::TagW'(tag_r[0]);
          last_nxt = (cmd.op == spq_pkg::OpPeek) || stat.single;
        end
      end
      spq_pkg::OpDumpNext: begin
        valid_nxt = 1'b1;
        st_nxt    = spq_pkg::StOk;
        okey_nxt  = key_r[idx_r];
        otag_nxt  = spq_pkg::TagW'(tag_r[idx_r]);
        last_nxt  = stat.dump_last;
        idx_nxt   = idx_r + IdxW'(1);
      end
      default: begin
        valid_nxt = 1'b0;
      end
    endcase
    occ_nxt = valid_nxt ? spq_pkg::OccW'(count_nxt) : occ_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    tag_r  <= tag_nxt;
    st_r   <= st_nxt;
    okey_r <= okey_nxt;
    otag_r <= otag_nxt;
    occ_r  <= occ_nxt;
    last_r <= last_nxt;
    if (cmd.capture) begin
      cmd_r    <= in_command;
      in_key_r <= in_key;
      in_tag_r <= spq_pkg::TagBits'(in_tag);
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = st_r;
  assign out_key       = okey_r;
  assign out_tag       = otag_r;
  assign out_occupancy = occ_r;
  assign out_last      = last_r;

endmodule

>>> rtl/sorted_priority_queue_core.sv
// top level of the sorted priority queue: controller plus entry datapath
// depends on spq_pkg, spq_ctrl and spq_datapath
//
// usage:
//   an item (in_command, in_key, in_tag) is taken at a rising edge with start
//   high and busy low. commands: enqueue, dequeue, peek, dump.
//   results come out on out_* marked by out_valid, one cycle each; the
//   receiver must take them, there is no back pressure.
//   out_last is high on the final result of an item.
// sequencing:
//   enqueue, dequeue and peek: busy is high for a single cycle while the
//   result is formed, which is registered onto the ports as busy drops. the
//   insert is a single compare-and-shift across the whole entry row.
//   dump: one result per held entry, one per cycle, head first, as the dump
//   pointer walks the row; busy stays high until the last result is
//   registered. an empty queue gives a single empty result.
//   a new item may be accepted in the cycle its predecessor's last result
//   is on the ports.
// reset:
//   synchronous, active low; empties the queue and drops any result in flight.
module sorted_priority_queue_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [spq_pkg::CmdW-1:0]        in_command,
  input  logic signed [spq_pkg::KeyW-1:0] in_key,
  input  logic [spq_pkg::TagW-1:0]        in_tag,
  output logic                            out_valid,
  output logic [spq_pkg::StW-1:0]         out_status,
  output logic signed [spq_pkg::KeyW-1:0] out_key,
  output logic [spq_pkg::TagW-1:0]        out_tag,
  output logic [spq_pkg::OccW-1:0]        out_occupancy,
  output logic                            out_last
);

  spq_pkg::ctrl_cmd_t cmd;
  spq_pkg::dp_stat_t  stat;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  spq_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_command    (in_command),
    .in_key        (in_key),
    .in_tag        (in_tag),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_key       (out_key),
    .out_tag       (out_tag),
    .out_occupancy (out_occupancy),
    .out_last      (out_last)
  );

endmodule

>>> rtl/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_core
module spq_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic [spq_pkg::StW-1:0]  out_status,
  input logic [spq_pkg::OccW-1:0] out_occupancy,
  input logic                     out_last
);

  // an accepted item raises busy, with no result out, in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accept not followed by busy cycle");

  // a dump keeps streaming until its last item
  a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("result stream broke before last");

  // final result of an item frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("busy on final result");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == spq_pkg::StFull) |->
      (out_occupancy == spq_pkg::OccW'(spq_pkg::Depth)) && out_last)
    else $error("full status with wrong occupancy");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == spq_pkg::StEmpty) |-> (out_occupancy == '0) && out_last)
    else $error("empty status with entries held");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_occupancy (out_occupancy),
  .out_last      (out_last)
);

>>> test/testbench.sv
// self-checking testbench for sorted_priority_queue_core
// depends on spq_pkg and the rtl of the block; tracks the sorted entry list to
// predict every result and checks the result stream against it
`timescale 1ns / 100ps

import spq_pkg::*;

class sorted_queue_tracker;
  typedef struct {
    logic [StW-1:0]         status;
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
    logic [OccW-1:0]        occ;
    logic                   last;
  } queue_result_t;

  logic signed [KeyW-1:0] held_keys [Depth];
  logic [TagW-1:0]        held_tags [Depth];
  int                     held_count;
  queue_result_t          pending_results [$];
  int                     errors;

  function new();
    held_count = 0;
    errors = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void add_result(logic [StW-1:0] st, logic signed [KeyW-1:0] k,
                           logic [TagW-1:0] t, logic lst);
    queue_result_t r;
    r.status = st;
    r.key = k;
    r.tag = t;
    r.occ = OccW'(held_count);
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function void add_head(logic [StW-1:0] st);
    if (held_count > 0) add_result(st, held_keys[0], held_tags[0], 1'b1);
    else add_result(st, '0, '0, 1'b1);
  endfunction

  // called at the edge where an item is taken
  function void take_command(logic [CmdW-1:0] cmd, logic signed [KeyW-1:0] key,
                             logic [TagW-1:0] tag);
    int pos;
    int i;
    case (cmd)
      CmdEnq: begin
        if (held_count >= Depth) begin
          add_head(StFull);
        end else begin
          // stable insert: behind every entry with key <= new key
          pos = 0;
          while (pos < held_count && held_keys[pos] <= key) pos++;
          for (i = held_count; i > pos; i--) begin
            held_keys[i] = held_keys[i-1];
            held_tags[i] = held_tags[i-1];
          end
          held_keys[pos] = key;
          held_tags[pos] = tag;
          held_count++;
          add_head(StOk);
        end
      end
      CmdDeq: begin
        if (held_count == 0) begin
          add_head(StEmpty);
        end else begin
          for (i = 1; i < held_count; i++) begin
            held_keys[i-1] = held_keys[i];
            held_tags[i-1] = held_tags[i];
          end
          held_count--;
          add_head(StOk);
        end
      end
      CmdPeek: add_head(held_count == 0 ? StEmpty : StOk);
      CmdDump: begin
        if (held_count == 0) begin
          add_head(StEmpty);
        end else begin
          for (i = 0; i < held_count; i++)
            add_result(StOk, held_keys[i], held_tags[i], i + 1 == held_count);
        end
      end
      default: ;
    endcase
  endfunction

  function void match_result(logic [StW-1:0] st, logic signed [KeyW-1:0] key,
                             logic [TagW-1:0] tag, logic [OccW-1:0] occ, logic lst);
    queue_result_t exp_r;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result status=%0d key=%0d tag=%h occ=%0d last=%b",
               $time, st, key, tag, occ, lst);
      return;
    end
    exp_r = pending_results.pop_front();
    if (st !== exp_r.status) begin
      errors++;
      $display("%0t: status expected %0d actual %0d", $time, exp_r.status, st);
    end
    if (key !== exp_r.key) begin
      errors++;
      $display("%0t: key expected %0d actual %0d", $time, exp_r.key, key);
    end
    if (tag !== exp_r.tag) begin
      errors++;
      $display("%0t: tag expected %h actual %h", $time, exp_r.tag, tag);
    end
    if (occ !== exp_r.occ) begin
      errors++;
      $display("%0t: occupancy expected %0d actual %0d", $time, exp_r.occ, occ);
    end
    if (lst !== exp_r.last) begin
      errors++;
      $display("%0t: last expected %b actual %b", $time, exp_r.last, lst);
    end
  endfunction
endclass

module testbench;
  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [CmdW-1:0]        in_command;
  logic signed [KeyW-1:0] in_key;
  logic [TagW-1:0]        in_tag;
  logic                   out_valid;
  logic [StW-1:0]         out_status;
  logic signed [KeyW-1:0] out_key;
  logic [TagW-1:0]        out_tag;
  logic [OccW-1:0]        out_occupancy;
  logic                   out_last;

  sorted_queue_tracker tracker = new();
  int idle_pct;
  bit fill_mode;

  sorted_priority_queue_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_key       (in_key),
    .in_tag       (in_tag),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_key      (out_key),
    .out_tag      (out_tag),
    .out_occupancy(out_occupancy),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.match_result(out_status, out_key, out_tag, out_occupancy, out_last);
  end

  initial begin
    #2_000_000;
    $display("FAIL sorted_priority_queue_core");
    $finish;
  end

  // holds the item until the block takes it
  task automatic send_item(logic [CmdW-1:0] cmd, logic signed [KeyW-1:0] key,
                           logic [TagW-1:0] tag);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_command <= cmd;
    in_key <= key;
    in_tag <= tag;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    tracker.take_command(cmd, key, tag);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  function automatic logic signed [KeyW-1:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom();
      1: return int'($urandom_range(6)) - 3;  // narrow range so keys collide
      2: begin
        case ($urandom_range(3))
          0: return {1'b1, {(KeyW-1){1'b0}}};
          1: return {1'b0, {(KeyW-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return int'($urandom_range(2000)) - 1000;
    endcase
  endfunction

  task automatic run_random(int pct, int count);
    int r;
    logic [CmdW-1:0] cmd;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      // swing between filling and draining so full and empty both come up
      if (tracker.held_count >= Depth && $urandom_range(2) == 0) fill_mode = 1'b0;
      else if (tracker.held_count == 0 && $urandom_range(1) == 0) fill_mode = 1'b1;
      else if ($urandom_range(19) == 0) fill_mode = !fill_mode;
      r = $urandom_range(99);
      if (fill_mode)
        cmd = r < 62 ? CmdEnq : r < 80 ? CmdDeq : r < 92 ? CmdPeek : CmdDump;
      else
        cmd = r < 25 ? CmdEnq : r < 75 ? CmdDeq : r < 90 ? CmdPeek : CmdDump;
      send_item(cmd, pick_key(), 16'($urandom()));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CmdEnq;
    in_key = '0;
    in_tag = '0;
    idle_pct = 0;
    fill_mode = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty queue on every command that reads it
    send_item(CmdPeek, '1, '1);
    send_item(CmdDeq, '0, '0);
    send_item(CmdDump, '0, '0);
    send_item(CmdEnq, {1'b0, {(KeyW-1){1'b1}}}, 16'h0000);
    send_item(CmdEnq, {1'b1, {(KeyW-1){1'b0}}}, 16'hffff);
    send_item(CmdEnq, 32'sd0, 16'h0001);
    // equal key must land behind the older one
    send_item(CmdEnq, 32'sd0, 16'h0002);
    send_item(CmdEnq, -32'sd1, 16'h5a5a);
    send_item(CmdPeek, '0, '0);
    send_item(CmdDump, '0, '0);
    send_item(CmdDeq, '0, '0);
    for (int n = 0; n < 12; n++) send_item(CmdEnq, pick_key(), 16'($urandom()));
    // full queue drops the item
    send_item(CmdEnq, 32'sd7, 16'hbeef);
    send_item(CmdDump, '0, '0);
    wait_drained();

    run_random(0, 52);
    wait_drained();
    run_random(68, 52);
    run_random(0, 52);
    wait_drained();
    run_random(15, 52);

    wait_drained();
    repeat (24) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS sorted_priority_queue_core");
    end else begin
      $display("FAIL sorted_priority_queue_core");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue_core.sv
rtl/spq_checker.sv
test/testbench.sv
